### rtl/fnu_pkg.sv
// ----------------------------------------------------------------------------
// fnu_pkg
// Shared types and constants of the farthest-next-use cache policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package fnu_pkg;

   // Field widths fixed by the interface
   localparam int KEY_W  = 32;
   localparam int NU_W   = 32;
   localparam int CAP_W  = 7;
   localparam int MISS_W = 32;

   // Capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Miss counter saturation value
   localparam logic [MISS_W-1:0] MISS_MAX = '1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_DECIDE,
      ST_WRITE2,
      ST_RESULT
   } state_type;

   // One cache entry as held in the entry store
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [NU_W-1:0]  next_use;
   } entry_type;

   // Scan outcome flags
   typedef struct packed {
      logic hit_found;
      logic vic_found;
      logic free_found;
   } scan_flags_type;

endpackage

`default_nettype wire

### rtl/fnu_scan.sv
// ----------------------------------------------------------------------------
// fnu_scan
// Entry store with a registered read port and the shared compare unit. Each
// entry read is checked for a key match, for the farthest next use among
// valid entries and for the first free slot, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fnu_scan
   import fnu_pkg::*;
#(
   parameter int ENTRIES = 64,
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 scan_start,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  entry_type            wr_data,
   input  logic [KEY_W-1:0]     key,
   output scan_flags_type       flags,
   output logic [IDX_W-1:0]     hit_idx,
   output logic [IDX_W-1:0]     vic_idx,
   output logic [KEY_W-1:0]     vic_key,
   output logic [IDX_W-1:0]     free_idx
);

   entry_type        mem [ENTRIES];
   entry_type        rd_data_ff;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;

   scan_flags_type   flags_ff,    flags_in;
   logic [IDX_W-1:0] hit_idx_ff,  hit_idx_in;
   logic [IDX_W-1:0] vic_idx_ff,  vic_idx_in;
   logic [KEY_W-1:0] vic_key_ff,  vic_key_in;
   logic [NU_W-1:0]  vic_nu_ff,   vic_nu_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   logic key_eq;
   logic nu_gt;

   // Entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Tag for the entry now in the read register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= rd_en;
      end
      cmp_idx_ff <= rd_addr;
   end

   // Shared compare unit
   assign key_eq = (rd_data_ff.key == key);
   assign nu_gt  = (rd_data_ff.next_use > vic_nu_ff);

   // Trackers: first match, farthest next use (lowest index on ties), first free
   always_comb begin
      flags_in    = flags_ff;
      hit_idx_in  = hit_idx_ff;
      vic_idx_in  = vic_idx_ff;
      vic_key_in  = vic_key_ff;
      vic_nu_in   = vic_nu_ff;
      free_idx_in = free_idx_ff;
      if (scan_start) begin
         flags_in = '0;
      end else if (cmp_vld_ff) begin
         if (rd_data_ff.valid) begin
            if (!flags_ff.hit_found && key_eq) begin
               flags_in.hit_found = 1'b1;
               hit_idx_in         = cmp_idx_ff;
            end
            if (!flags_ff.vic_found || nu_gt) begin
               flags_in.vic_found = 1'b1;
               vic_idx_in         = cmp_idx_ff;
               vic_key_in         = rd_data_ff.key;
               vic_nu_in          = rd_data_ff.next_use;
            end
         end else if (!flags_ff.free_found) begin
            flags_in.free_found = 1'b1;
            free_idx_in         = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      hit_idx_ff  <= hit_idx_in;
      vic_idx_ff  <= vic_idx_in;
      vic_key_ff  <= vic_key_in;
      vic_nu_ff   <= vic_nu_in;
      free_idx_ff <= free_idx_in;
   end

   assign flags    = flags_ff;
   assign hit_idx  = hit_idx_ff;
   assign vic_idx  = vic_idx_ff;
   assign vic_key  = vic_key_ff;
   assign free_idx = free_idx_ff;

   // The victim is always taken from a valid entry
   a_vic_from_valid: assert property (@(posedge clock) disable iff (reset)
      (cmp_vld_ff && !rd_data_ff.valid) |=> (vic_idx_ff == $past(vic_idx_ff)))
      else $error("victim index moved on a free entry");

   // A free slot is never recorded at a valid entry
   a_free_stable: assert property (@(posedge clock) disable iff (reset)
      (cmp_vld_ff && rd_data_ff.valid && !scan_start) |=> (flags_ff.free_found ==
      $past(flags_ff.free_found)))
      else $error("free slot flag changed on a valid entry");

   // Hit index only set once per scan
   a_hit_once: assert property (@(posedge clock) disable iff (reset)
      (flags_ff.hit_found && !scan_start) |=> (flags_ff.hit_found &&
      hit_idx_ff == $past(hit_idx_ff)))
      else $error("hit index changed after first match");

endmodule

`default_nettype wire

### rtl/farthest_next_use_cache_policy.sv
// ----------------------------------------------------------------------------
// farthest_next_use_cache_policy
// Per item: accept in IDLE, SCAN of every entry, FINISH, DECIDE, RESULT, with a
// WRITE2 state after DECIDE when an eviction and an insert land in different slots
// (two store writes). RESULT waits while the response register is stalled. A new
// item is taken only in IDLE; the entry store scan runs one entry per cycle
// through a single compare unit. Reset: a clearing pass sweeps the entry store;
// req_stall stays high until it ends. Capacity writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module farthest_next_use_cache_policy
   import fnu_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KEY_W-1:0]  req_key,
   input  logic              req_has_next_use,
   input  logic [NU_W-1:0]   req_next_use,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic              rsp_evicted_valid,
   output logic [KEY_W-1:0]  rsp_evicted_key,
   output logic [MISS_W-1:0] rsp_miss_total,
   // capacity register write
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CMP_W-1:0] ENT_CMP  = CMP_W'(ENTRIES);
   localparam logic [OCC_W-1:0] OCC_MAX  = OCC_W'(ENTRIES);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  addr_ff,  addr_in;
   logic [OCC_W-1:0]  occ_ff,   occ_in;
   logic [MISS_W-1:0] miss_ff,  miss_in;
   logic              ev_ff,    ev_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              future_ff;
   logic [NU_W-1:0]   nu_ff;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic              rsp_ev_ff;
   logic [KEY_W-1:0]  rsp_ev_key_ff;
   logic [MISS_W-1:0] rsp_miss_ff;

   logic              scan_start;
   logic              rd_en;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   entry_type         new_entry;
   logic              rsp_load;
   logic              accept;

   scan_flags_type    flags;
   logic [IDX_W-1:0]  hit_idx;
   logic [IDX_W-1:0]  vic_idx;
   logic [KEY_W-1:0]  vic_key;
   logic [IDX_W-1:0]  free_idx;

   logic [CMP_W-1:0]  cap_ext;
   logic [CMP_W-1:0]  eff_cap;
   logic              occ_full;

   // Entry store and scan unit
   fnu_scan #(.ENTRIES(ENTRIES)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_start (scan_start),
      .rd_en      (rd_en),
      .rd_addr    (addr_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .key        (key_ff),
      .flags      (flags),
      .hit_idx    (hit_idx),
      .vic_idx    (vic_idx),
      .vic_key    (vic_key),
      .free_idx   (free_idx)
   );

   // Capacity register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   // Effective capacity: zero means one, clamp to store depth
   assign cap_ext  = CMP_W'(cap_ff);
   assign eff_cap  = (cap_ff == '0) ? CMP_W'(1) : ((cap_ext > ENT_CMP) ? ENT_CMP : cap_ext);
   assign occ_full = (CMP_W'(occ_ff) >= eff_cap);

   assign new_entry = '{valid: 1'b1, key: key_ff, next_use: nu_ff};
   assign accept    = req_valid && !req_stall;

   // Sequencer: next state and store control
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      occ_in     = occ_ff;
      miss_in    = miss_ff;
      ev_in      = ev_ff;
      scan_start = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = addr_ff;
      wr_data    = '0;
      rsp_load   = 1'b0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               scan_start = 1'b1;
               addr_in    = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_FINISH;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            // last entry is checked at this edge
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_RESULT;
            ev_in    = 1'b0;
            if (flags.hit_found) begin
               // refresh next use, or drop the entry
               wr_en   = 1'b1;
               wr_addr = hit_idx;
               wr_data = '{valid: future_ff, key: key_ff, next_use: nu_ff};
               if (!future_ff && occ_ff != '0) begin
                  occ_in = occ_ff - OCC_W'(1);
               end
            end else begin
               if (miss_ff != MISS_MAX) begin
                  miss_in = miss_ff + MISS_W'(1);
               end
               if (occ_full && flags.vic_found) begin
                  ev_in   = 1'b1;
                  wr_en   = 1'b1;
                  wr_addr = vic_idx;
                  if (future_ff && flags.free_found && (free_idx < vic_idx)) begin
                     // clear victim now, insert at the lower free slot next
                     state_in = ST_WRITE2;
                  end else if (future_ff) begin
                     wr_data = new_entry;
                  end else if (occ_ff != '0) begin
                     occ_in = occ_ff - OCC_W'(1);
                  end
               end else if (future_ff && flags.free_found) begin
                  wr_en   = 1'b1;
                  wr_addr = free_idx;
                  wr_data = new_entry;
                  occ_in  = occ_ff + OCC_W'(1);
               end
            end
         end
         ST_WRITE2: begin
            wr_en    = 1'b1;
            wr_addr  = free_idx;
            wr_data  = new_entry;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         occ_ff   <= '0;
         miss_ff  <= '0;
         ev_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         occ_ff   <= occ_in;
         miss_ff  <= miss_in;
         ev_ff    <= ev_in;
      end
   end

   // Captured item
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff    <= req_key;
         future_ff <= req_has_next_use;
         nu_ff     <= req_next_use;
      end
   end

   // Response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff    <= flags.hit_found;
         rsp_ev_ff     <= ev_ff;
         rsp_ev_key_ff <= ev_ff ? vic_key : '0;
         rsp_miss_ff   <= miss_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_key   = rsp_ev_key_ff;
   assign rsp_miss_total    = rsp_miss_ff;

   // An accepted item always starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");

   // A new response only comes out of the result state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESULT))
      else $error("response raised outside the result state");

   // Occupancy never exceeds the store depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (occ_ff <= OCC_MAX))
      else $error("occupancy above store depth");

   // The second write is only used after an eviction
   a_write2_ev: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE2) |-> (ev_ff && !flags.hit_found))
      else $error("second write without an eviction");

endmodule

`default_nettype wire
